FILE: src/acs_pkg.sv
package acs_pkg;

    localparam int CP_W = 21;
    localparam int FORM_W = 16;

    localparam logic [CP_W-1:0] CP_LAM     = 21'h00644;
    localparam logic [CP_W-1:0] CP_TATWEEL = 21'h00640;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_RIGHT,
        JC_DUAL,
        JC_CAUSING
    } t_jclass;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic              eos;
        t_jclass           jclass;
        logic [FORM_W-1:0] iso;
        logic              is_alef;
        logic [FORM_W-1:0] lig;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [CP_W-1:0] pt;
        logic            joins;
    } t_shape;

    function automatic t_item f_classify(input logic [CP_W-1:0] cp, input logic eos);
        t_item it;
        it.cp      = cp;
        it.eos     = eos;
        it.jclass  = JC_NONE;
        it.iso     = '0;
        it.is_alef = 1'b0;
        it.lig     = '0;
        case (cp)
            CP_TATWEEL: it.jclass = JC_CAUSING;
            // Right-joining letters; the four alefs also carry their lam-alef ligature.
            21'h00622: begin it.jclass = JC_RIGHT; it.iso = 16'hFE81;
                             it.is_alef = 1'b1; it.lig = 16'hFEFB; end
            21'h00623: begin it.jclass = JC_RIGHT; it.iso = 16'hFE83;
                             it.is_alef = 1'b1; it.lig = 16'hFEF7; end
            21'h00624: begin it.jclass = JC_RIGHT; it.iso = 16'hFE85; end
            21'h00625: begin it.jclass = JC_RIGHT; it.iso = 16'hFE87;
                             it.is_alef = 1'b1; it.lig = 16'hFEF9; end
            21'h00627: begin it.jclass = JC_RIGHT; it.iso = 16'hFE8D;
                             it.is_alef = 1'b1; it.lig = 16'hFEF5; end
            21'h00629: begin it.jclass = JC_RIGHT; it.iso = 16'hFE93; end
            21'h0062F: begin it.jclass = JC_RIGHT; it.iso = 16'hFEA9; end
            21'h00630: begin it.jclass = JC_RIGHT; it.iso = 16'hFEAB; end
            21'h00631: begin it.jclass = JC_RIGHT; it.iso = 16'hFEAD; end
            21'h00632: begin it.jclass = JC_RIGHT; it.iso = 16'hFEAF; end
            21'h00648: begin it.jclass = JC_RIGHT; it.iso = 16'hFEED; end
            21'h00649: begin it.jclass = JC_RIGHT; it.iso = 16'hFEEF; end
            21'h00671: begin it.jclass = JC_RIGHT; it.iso = 16'hFB50; end
            // Dual-joining letters.
            21'h00626: begin it.jclass = JC_DUAL; it.iso = 16'hFE89; end
            21'h00628: begin it.jclass = JC_DUAL; it.iso = 16'hFE8F; end
            21'h0062A: begin it.jclass = JC_DUAL; it.iso = 16'hFE95; end
            21'h0062B: begin it.jclass = JC_DUAL; it.iso = 16'hFE99; end
            21'h0062C: begin it.jclass = JC_DUAL; it.iso = 16'hFE9D; end
            21'h0062D: begin it.jclass = JC_DUAL; it.iso = 16'hFEA1; end
            21'h0062E: begin it.jclass = JC_DUAL; it.iso = 16'hFEA5; end
            21'h00633: begin it.jclass = JC_DUAL; it.iso = 16'hFEB1; end
            21'h00634: begin it.jclass = JC_DUAL; it.iso = 16'hFEB5; end
            21'h00635: begin it.jclass = JC_DUAL; it.iso = 16'hFEB9; end
            21'h00636: begin it.jclass = JC_DUAL; it.iso = 16'hFEBD; end
            21'h00637: begin it.jclass = JC_DUAL; it.iso = 16'hFEC1; end
            21'h00638: begin it.jclass = JC_DUAL; it.iso = 16'hFEC5; end
            21'h00639: begin it.jclass = JC_DUAL; it.iso = 16'hFEC9; end
            21'h0063A: begin it.jclass = JC_DUAL; it.iso = 16'hFECD; end
            21'h00641: begin it.jclass = JC_DUAL; it.iso = 16'hFED1; end
            21'h00642: begin it.jclass = JC_DUAL; it.iso = 16'hFED5; end
            21'h00643: begin it.jclass = JC_DUAL; it.iso = 16'hFED9; end
            CP_LAM:    begin it.jclass = JC_DUAL; it.iso = 16'hFEDD; end
            21'h00645: begin it.jclass = JC_DUAL; it.iso = 16'hFEE1; end
            21'h00646: begin it.jclass = JC_DUAL; it.iso = 16'hFEE5; end
            21'h00647: begin it.jclass = JC_DUAL; it.iso = 16'hFEE9; end
            21'h0064A: begin it.jclass = JC_DUAL; it.iso = 16'hFEF1; end
            21'h0066E: begin it.jclass = JC_DUAL; it.iso = 16'hFB56; end
            21'h0066F: begin it.jclass = JC_DUAL; it.iso = 16'hFB62; end
            default:   it.jclass = JC_NONE;
        endcase
        return it;
    endfunction

    // Picks the glyph for one character given both neighbors' joining.
    function automatic t_shape f_shape(input t_item it, input logic prev_joins,
                                       input logic next_joins);
        t_shape sh;
        sh.pt    = it.cp;
        sh.joins = 1'b0;
        case (it.jclass)
            JC_CAUSING: sh.joins = next_joins;
            JC_RIGHT: begin
                sh.pt = {{(CP_W-FORM_W){1'b0}}, it.iso + {{(FORM_W-1){1'b0}}, prev_joins}};
            end
            JC_DUAL: begin
                sh.pt = {{(CP_W-FORM_W){1'b0}},
                         it.iso + {{(FORM_W-2){1'b0}}, next_joins, prev_joins}};
                sh.joins = next_joins;
            end
            default: sh.joins = 1'b0;
        endcase
        return sh;
    endfunction

endpackage

FILE: src/acs_in_if.sv
interface acs_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        end_of_string;

    modport source (output valid, output code_point, output end_of_string, input ready);
    modport sink   (input valid, input code_point, input end_of_string, output ready);
endinterface

FILE: src/acs_out_if.sv
interface acs_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] shaped_point;
    logic        last_out;

    modport source (output valid, output shaped_point, output last_out, input ready);
    modport sink   (input valid, input shaped_point, input last_out, output ready);
endinterface

FILE: src/acs_front.sv
module acs_front (
    acs_in_if.sink            i_in,
    input  acs_pkg::t_q_status i_q_status,
    output logic              o_push,
    output acs_pkg::t_item    o_item
);
    import acs_pkg::*;

    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;
    assign o_item     = f_classify(i_in.code_point, i_in.end_of_string);

endmodule

FILE: src/acs_queue.sv
module acs_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  acs_pkg::t_item     i_item,
    input  logic               i_pop,
    output acs_pkg::t_item     o_head,
    output acs_pkg::t_q_status o_status
);
    import acs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/acs_back.sv
module acs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acs_pkg::t_item     i_head,
    input  acs_pkg::t_q_status i_q_status,
    output logic               o_pop,
    acs_out_if.source          o_out
);
    import acs_pkg::*;

    t_item           r_held;
    logic            r_held_valid;
    logic            r_prev_joins;
    logic            r_flush;
    logic            r_out_valid;
    logic [CP_W-1:0] r_out_pt;
    logic            r_out_last;

    t_item           n_held;
    logic            n_held_valid;
    logic            n_prev_joins;
    logic            n_flush;
    logic            n_out_valid;
    logic [CP_W-1:0] n_out_pt;
    logic            n_out_last;

    logic   can_emit;
    t_shape sh_flush;
    t_shape sh_next;

    assign can_emit = !r_out_valid || o_out.ready;
    assign sh_flush = f_shape(r_held, r_prev_joins, 1'b0);
    assign sh_next  = f_shape(r_held, r_prev_joins, i_head.jclass != JC_NONE);

    always_comb begin
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_prev_joins = r_prev_joins;
        n_flush      = r_flush;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_pt     = r_out_pt;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        if (can_emit) begin
            if (r_flush) begin
                // End of string: the held character has no successor.
                n_out_valid  = 1'b1;
                n_out_pt     = sh_flush.pt;
                n_out_last   = 1'b1;
                n_held_valid = 1'b0;
                n_prev_joins = 1'b0;
                n_flush      = 1'b0;
            end else if (!i_q_status.empty) begin
                o_pop = 1'b1;
                if (r_held_valid) begin
                    n_out_valid = 1'b1;
                    if (r_held.cp == CP_LAM && i_head.is_alef) begin
                        // Lam and alef merge; both characters are consumed.
                        n_out_pt = {{(CP_W-FORM_W){1'b0}},
                                    i_head.lig + {{(FORM_W-1){1'b0}}, r_prev_joins}};
                        n_out_last   = i_head.eos;
                        n_held_valid = 1'b0;
                        n_prev_joins = 1'b0;
                    end else begin
                        n_out_pt     = sh_next.pt;
                        n_out_last   = 1'b0;
                        n_prev_joins = sh_next.joins;
                        n_held       = i_head;
                        n_held_valid = 1'b1;
                        n_flush      = i_head.eos;
                    end
                end else begin
                    n_held       = i_head;
                    n_held_valid = 1'b1;
                    n_flush      = i_head.eos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_out_pt   <= n_out_pt;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_prev_joins <= 1'b0;
            r_flush      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_prev_joins <= n_prev_joins;
            r_flush      <= n_flush;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.shaped_point = r_out_pt;
    assign o_out.last_out     = r_out_last;

endmodule

FILE: src/arabic_contextual_shaper_unit.sv
// Streaming Arabic shaper: one code point per item in logical order, one shaped item out
// per character, with a lam-alef pair merged into a single ligature item. An item is taken
// in every cycle while the small queue between classifier and shaper has room, and a result
// is written to the output register when the shaper handles its successor; a character
// waits in the shaper until the next one (or the end of string) arrives. After an
// end-of-string item the shaper flushes the held character in a separate step, unless the
// string closes with a lam-alef pair, which leaves nothing to flush. Results are delivered
// in order and last_out marks the final one.
module arabic_contextual_shaper_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acs_in_if.sink     i_in,
    acs_out_if.source  o_out
);
    import acs_pkg::*;

    logic      push;
    logic      pop;
    t_item     push_item;
    t_item     head_item;
    t_q_status q_status;

    acs_front u_front (
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    acs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    acs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

FILE: src/acs_checker.sv
module acs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_out_point,
    input logic        i_out_last
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_point) && $stable(i_out_last))
        else $error("output item changed while stalled");

    // Reset empties the output register and the queue.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");

    // Nothing can come out of a block that has taken no item since reset
    // unless an output is already waiting.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_out_valid) && !$past(i_in_valid && i_in_ready) && !$past(i_rst_n, 2) == 1'b0
        && !$past(i_out_valid, 2) && !$past(i_in_valid && i_in_ready, 2)
        && !$past(i_in_valid && i_in_ready, 3) && !$past(i_out_valid, 3)
        && $past(i_rst_n, 3) == 1'b0 |-> !i_out_valid)
        else $error("output item without any input");

endmodule

bind arabic_contextual_shaper_unit acs_checker u_acs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_point (o_out.shaped_point),
    .i_out_last  (o_out.last_out)
);

FILE: dv/arabic_contextual_shaper_unit_test.sv
module arabic_contextual_shaper_unit_test;
    import acs_pkg::*;

    localparam int CHAR_COUNT     = 1450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [CP_W-1:0] pt;
        logic            last;
    } t_glyph;

    // Shapes the character stream on its own and checks each glyph item the block returns.
    class glyph_predictor;
        t_glyph          expected_glyphs[$];
        logic [CP_W-1:0] held_pt   = '0;
        bit              held_vld  = 1'b0;
        bit              prev_join = 1'b0;
        int              errors    = 0;

        function void report(string msg);
            errors++;
            $display("shaper mismatch at %0t: %s", $time, msg);
        endfunction

        function logic [CP_W-1:0] dual_iso(logic [CP_W-1:0] cp);
            case (cp)
                21'h00626: return 21'h0FE89;
                21'h00628: return 21'h0FE8F;
                21'h0062A: return 21'h0FE95;
                21'h0062B: return 21'h0FE99;
                21'h0062C: return 21'h0FE9D;
                21'h0062D: return 21'h0FEA1;
                21'h0062E: return 21'h0FEA5;
                21'h00633: return 21'h0FEB1;
                21'h00634: return 21'h0FEB5;
                21'h00635: return 21'h0FEB9;
                21'h00636: return 21'h0FEBD;
                21'h00637: return 21'h0FEC1;
                21'h00638: return 21'h0FEC5;
                21'h00639: return 21'h0FEC9;
                21'h0063A: return 21'h0FECD;
                21'h00641: return 21'h0FED1;
                21'h00642: return 21'h0FED5;
                21'h00643: return 21'h0FED9;
                21'h00644: return 21'h0FEDD;
                21'h00645: return 21'h0FEE1;
                21'h00646: return 21'h0FEE5;
                21'h00647: return 21'h0FEE9;
                21'h0064A: return 21'h0FEF1;
                21'h0066E: return 21'h0FB56;
                21'h0066F: return 21'h0FB62;
                default:   return '0;
            endcase
        endfunction

        function logic [CP_W-1:0] right_iso(logic [CP_W-1:0] cp);
            case (cp)
                21'h00622: return 21'h0FE81;
                21'h00623: return 21'h0FE83;
                21'h00624: return 21'h0FE85;
                21'h00625: return 21'h0FE87;
                21'h00627: return 21'h0FE8D;
                21'h00629: return 21'h0FE93;
                21'h0062F: return 21'h0FEA9;
                21'h00630: return 21'h0FEAB;
                21'h00631: return 21'h0FEAD;
                21'h00632: return 21'h0FEAF;
                21'h00648: return 21'h0FEED;
                21'h00649: return 21'h0FEEF;
                21'h00671: return 21'h0FB50;
                default:   return '0;
            endcase
        endfunction

        function logic [CP_W-1:0] lig_form(logic [CP_W-1:0] alef);
            case (alef)
                21'h00627: return 21'h0FEF5;
                21'h00623: return 21'h0FEF7;
                21'h00625: return 21'h0FEF9;
                21'h00622: return 21'h0FEFB;
                default:   return '0;
            endcase
        endfunction

        function t_jclass join_class(logic [CP_W-1:0] cp);
            if (cp == CP_TATWEEL) return JC_CAUSING;
            if (right_iso(cp) != '0) return JC_RIGHT;
            if (dual_iso(cp) != '0) return JC_DUAL;
            return JC_NONE;
        endfunction

        function logic [CP_W-1:0] shape_char(logic [CP_W-1:0] cp, bit next_joins);
            logic [CP_W-1:0] form;
            case (join_class(cp))
                JC_CAUSING: begin
                    form      = cp;
                    prev_join = next_joins;
                end
                JC_RIGHT: begin
                    form      = right_iso(cp) + prev_join;
                    prev_join = 1'b0;
                end
                JC_DUAL: begin
                    form      = dual_iso(cp) + {next_joins, prev_join};
                    prev_join = next_joins;
                end
                default: begin
                    form      = cp;
                    prev_join = 1'b0;
                end
            endcase
            return form;
        endfunction

        function void take_char(logic [CP_W-1:0] cp, logic eos);
            t_glyph made[2];
            int     n;
            bit     merged;
            n      = 0;
            merged = 1'b0;
            if (held_vld) begin
                // A held lam swallows a following alef into one ligature item.
                if (held_pt == CP_LAM && lig_form(cp) != '0) begin
                    made[0]   = '{pt: lig_form(cp) + prev_join, last: 1'b0};
                    prev_join = 1'b0;
                    merged    = 1'b1;
                end else begin
                    made[0] = '{pt: shape_char(held_pt, join_class(cp) != JC_NONE),
                                last: 1'b0};
                end
                n        = 1;
                held_vld = 1'b0;
                held_pt  = '0;
            end
            if (!merged) begin
                if (eos) begin
                    made[n] = '{pt: shape_char(cp, 1'b0), last: 1'b0};
                    n++;
                end else begin
                    held_pt  = cp;
                    held_vld = 1'b1;
                end
            end
            if (eos) begin
                made[n-1].last = 1'b1;
                held_pt   = '0;
                held_vld  = 1'b0;
                prev_join = 1'b0;
            end
            for (int k = 0; k < n; k++) expected_glyphs = {expected_glyphs, made[k]};
        endfunction

        function void check_glyph(logic [CP_W-1:0] pt, logic last);
            t_glyph want;
            if (expected_glyphs.size() == 0) begin
                report($sformatf("unexpected glyph %06h last=%b", pt, last));
                return;
            end
            want = expected_glyphs.pop_front();
            if (pt !== want.pt)
                report($sformatf("shaped_point %06h, expected %06h", pt, want.pt));
            if (last !== want.last)
                report($sformatf("last_out %b, expected %b (glyph %06h)",
                                 last, want.last, want.pt));
        endfunction

        function int pending();
            return expected_glyphs.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    acs_in_if  chars_in ();
    acs_out_if glyphs_out ();

    arabic_contextual_shaper_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chars_in),
        .o_out   (glyphs_out)
    );

    glyph_predictor shaper_model = new();
    int             chars_sent   = 0;
    int             idle_cycles  = 0;
    bit             steady       = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none at all during steady stretches.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic logic [CP_W-1:0] any_alef();
        case ($urandom_range(0, 3))
            0:       return 21'h00627;
            1:       return 21'h00623;
            2:       return 21'h00625;
            default: return 21'h00622;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return CP_W'($urandom_range(21'h00620, 21'h0064A));
        if (r < 58) begin
            case ($urandom_range(0, 2))
                0:       return 21'h0066E;
                1:       return 21'h0066F;
                default: return 21'h00671;
            endcase
        end
        if (r < 70) return CP_LAM;
        if (r < 78) return CP_TATWEEL;
        if (r < 82) return any_alef();
        if (r < 90) return CP_W'($urandom_range(0, 21'h0007F));
        if (r < 96) return CP_W'($urandom_range(0, 21'h1FFFFF));
        case ($urandom_range(0, 3))
            0:       return 21'h000000;
            1:       return 21'h1FFFFF;
            2:       return 21'h10FFFF;
            default: return 21'h010000;
        endcase
    endfunction

    task automatic push_char(input logic [CP_W-1:0] cp, input logic eos);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            chars_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        chars_in.valid         <= 1'b1;
        chars_in.code_point    <= cp;
        chars_in.end_of_string <= eos;
        do @(posedge i_clk); while (!chars_in.ready);
        shaper_model.take_char(cp, eos);
        chars_sent++;
    endtask

    // Holds the sender off until every glyph already owed has come back.
    task automatic wait_for_drain();
        chars_in.valid <= 1'b0;
        do @(posedge i_clk); while (shaper_model.pending() != 0);
    endtask

    task automatic send_random_string();
        int              len;
        bit              alef_next;
        logic [CP_W-1:0] cp;
        alef_next = 1'b0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            if (alef_next) begin
                cp        = any_alef();
                alef_next = 1'b0;
            end else begin
                cp        = pick_char();
                alef_next = (cp == CP_LAM) && ($urandom_range(0, 1) == 1);
            end
            push_char(cp, k == len - 1);
        end
    endtask

    initial begin
        glyphs_out.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            int burst;
            int stall;
            burst = $urandom_range(1, 20);
            stall = idle_len();
            glyphs_out.ready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            if (stall > 0) begin
                glyphs_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && glyphs_out.valid && glyphs_out.ready)
            shaper_model.check_glyph(glyphs_out.shaped_point, glyphs_out.last_out);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((chars_in.valid && chars_in.ready) || (glyphs_out.valid && glyphs_out.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("shaper watchdog expired with %0d glyphs outstanding",
                         shaper_model.pending());
                $display("arabic_contextual_shaper_unit_test: FAIL");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n                <= 1'b0;
        chars_in.valid         <= 1'b0;
        chars_in.code_point    <= '0;
        chars_in.end_of_string <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single characters: a dual letter, a right letter and the range extremes.
        push_char(21'h00628, 1'b1);
        push_char(21'h00671, 1'b1);
        push_char(21'h000000, 1'b1);
        push_char(21'h1FFFFF, 1'b1);
        push_char(21'h10FFFF, 1'b1);
        // Isolated lam-alef, then one joined to a preceding beh.
        push_char(CP_LAM, 1'b0);
        push_char(21'h00627, 1'b1);
        push_char(21'h00628, 1'b0);
        push_char(CP_LAM, 1'b0);
        push_char(21'h00623, 1'b1);
        // Medial forms, with a lam-alef after a joining lam.
        push_char(21'h00628, 1'b0);
        push_char(21'h00628, 1'b0);
        push_char(CP_LAM, 1'b0);
        push_char(CP_LAM, 1'b0);
        push_char(21'h00622, 1'b1);
        // Tatweel joins both ways; a right letter breaks the chain.
        push_char(CP_TATWEEL, 1'b0);
        push_char(21'h0066E, 1'b0);
        push_char(CP_TATWEEL, 1'b0);
        push_char(21'h00625, 1'b0);
        push_char(21'h0066F, 1'b0);
        push_char(21'h00041, 1'b0);
        push_char(CP_LAM, 1'b1);
        wait_for_drain();

        while (chars_sent < CHAR_COUNT) begin
            steady = ($urandom_range(0, 6) == 0);
            send_random_string();
            if ($urandom_range(0, 59) == 0)
                wait_for_drain();
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shaper_model.errors == 0)
            $display("arabic_contextual_shaper_unit_test: PASS");
        else
            $display("arabic_contextual_shaper_unit_test: FAIL");
        $finish;
    end

endmodule
